// File: rtl/core/expansion_board_autoconfig_defines.svh
// assertion macros shared by the autoconfig rtl
`ifndef EXPANSION_BOARD_AUTOCONFIG_DEFINES_SVH
`define EXPANSION_BOARD_AUTOCONFIG_DEFINES_SVH

// implication on the same clock edge
`define EAC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked on the next clock edge
`define EAC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/eac_pkg.sv
// ---------------------------------------------------------------------------
// eac_pkg
// types and codes shared by the expansion board autoconfig block
// ---------------------------------------------------------------------------
package eac_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // bus commands
    localparam logic [1:0] CMD_READ     = 2'd0;
    localparam logic [1:0] CMD_WRITE    = 2'd1;
    localparam logic [1:0] CMD_ACTIVATE = 2'd2;
    localparam logic [1:0] CMD_SHUTUP   = 2'd3;

    // board modes
    localparam logic [1:0] MODE_CONFIG = 2'd0;
    localparam logic [1:0] MODE_ACTIVE = 2'd1;
    localparam logic [1:0] MODE_SHUTUP = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BOARD_TYPE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE_COUNT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRODUCT_ID    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOARD_FLAGS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MAKER_ID      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SERIAL_NUMBER = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DIAG_VECTOR   = 3'd6;

    // bus offsets
    localparam logic [15:0] OFF_BASE_HI = 16'h0048;
    localparam logic [15:0] OFF_BASE_LO = 16'h004A;

    typedef struct packed {
        logic [7:0]  board_type;
        logic [7:0]  page_count;
        logic [7:0]  product_id;
        logic [7:0]  board_flags;
        logic [15:0] maker_id;
        logic [31:0] serial_number;
        logic [15:0] diag_vector;
    } eac_cfg_t;

endpackage

// File: rtl/core/expansion_board_autoconfig.sv
// ---------------------------------------------------------------------------
// expansion_board_autoconfig
// autoconfiguration register space of an expansion board
// ---------------------------------------------------------------------------
// Every accepted bus command yields one result in the next cycle, and a new
// command is taken every cycle as long as the result is collected; both
// are set by the single result register behind the read decoder.
// Reads return the nibble-encoded descriptor, writes to 0x48 and 0x4A
// collect base address bits 23..16, and the board mode and base address
// reported with each result are those after the command.
module expansion_board_autoconfig (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [eac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [eac_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [1:0]                     command,
    input  logic [15:0]                    address,
    input  logic [7:0]                     write_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [7:0]                     read_data,
    output logic [1:0]                     board_state,
    output logic [23:0]                    base_address
);
    import eac_pkg::*;

    eac_cfg_t   cfg;
    logic [7:0] rd_byte;
    logic       in_xfer;

    logic       out_valid_reg;
    logic [7:0] rdata_reg, rdata_next;
    logic [1:0] mode_reg, mode_next;
    logic [7:0] base_reg, base_next;

    eac_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    eac_read_dec u_read_dec (
        .cfg    (cfg),
        .offset (address[7:0]),
        .rdata  (rd_byte)
    );

    assign in_ready = !out_valid_reg || out_ready;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        rdata_next = 8'hFF;
        mode_next  = mode_reg;
        base_next  = base_reg;
        unique case (command)
            CMD_READ:
            begin
                rdata_next = rd_byte;
            end
            CMD_WRITE:
            begin
                if (address == OFF_BASE_HI)
                begin
                    base_next = base_reg | {write_data[7:4], 4'h0};
                    mode_next = MODE_ACTIVE;
                end
                else if (address == OFF_BASE_LO)
                begin
                    base_next = base_reg | {4'h0, write_data[7:4]};
                end
            end
            CMD_ACTIVATE: mode_next = MODE_ACTIVE;
            CMD_SHUTUP:   mode_next = MODE_SHUTUP;
            default:      ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            mode_reg      <= MODE_CONFIG;
            base_reg      <= 8'h00;
        end
        else
        begin
            if (in_xfer)
            begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                base_reg      <= base_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            rdata_reg <= rdata_next;
    end

    // mode and base only move on a new transfer, so they hold with the result
    assign out_valid    = out_valid_reg;
    assign read_data    = rdata_reg;
    assign board_state  = mode_reg;
    assign base_address = {base_reg, 16'h0000};

`include "expansion_board_autoconfig_defines.svh"

    `EAC_ASSERT_NEXT(a_activate_sets_mode, in_xfer && command == CMD_ACTIVATE, mode_reg == MODE_ACTIVE, "activate did not set active mode")
    `EAC_ASSERT_NEXT(a_base_never_clears, 1'b1, ($past(base_reg) & ~base_reg) == 8'h00, "base address bit cleared")
    `EAC_ASSERT_NEXT(a_nonread_ff, in_xfer && command != CMD_READ, read_data == 8'hFF, "non-read result not 0xFF")
    `EAC_ASSERT_SAME(a_stall_blocks_input, out_valid_reg && !out_ready, !in_ready, "input taken while result stalled")

endmodule

// File: rtl/core/eac_cfg_regs.sv
// ---------------------------------------------------------------------------
// eac_cfg_regs
// configuration register file holding the board descriptor fields
// ---------------------------------------------------------------------------
module eac_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [eac_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [eac_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output eac_pkg::eac_cfg_t              cfg
);
    import eac_pkg::*;

    eac_cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{board_type:    8'd0,
                         page_count:    8'd1,
                         product_id:    8'd0,
                         board_flags:   8'd0,
                         maker_id:      16'd0,
                         serial_number: 32'd0,
                         diag_vector:   16'd0};
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BOARD_TYPE:    cfg_reg.board_type    <= cfg_wdata[7:0];
                REG_PAGE_COUNT:    cfg_reg.page_count    <= cfg_wdata[7:0];
                REG_PRODUCT_ID:    cfg_reg.product_id    <= cfg_wdata[7:0];
                REG_BOARD_FLAGS:   cfg_reg.board_flags   <= cfg_wdata[7:0];
                REG_MAKER_ID:      cfg_reg.maker_id      <= cfg_wdata[15:0];
                REG_SERIAL_NUMBER: cfg_reg.serial_number <= cfg_wdata[31:0];
                REG_DIAG_VECTOR:   cfg_reg.diag_vector   <= cfg_wdata[15:0];
                default:           ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/core/eac_read_dec.sv
// ---------------------------------------------------------------------------
// eac_read_dec
// descriptor lookup and nibble encoding for bus reads
// ---------------------------------------------------------------------------
module eac_read_dec (
    input  eac_pkg::eac_cfg_t cfg,
    input  logic [7:0]        offset,
    output logic [7:0]        rdata
);
    import eac_pkg::*;

    logic [2:0] size_code;
    logic [7:0] desc_byte;
    logic [3:0] nib;

    // one-hot page count maps to its log2 plus one, 128 wraps to zero
    always_comb
    begin
        case (cfg.page_count)
            8'h01:   size_code = 3'd1;
            8'h02:   size_code = 3'd2;
            8'h04:   size_code = 3'd3;
            8'h08:   size_code = 3'd4;
            8'h10:   size_code = 3'd5;
            8'h20:   size_code = 3'd6;
            8'h40:   size_code = 3'd7;
            default: size_code = 3'd0;
        endcase
    end

    always_comb
    begin
        unique case (offset[5:2])
            4'd0:    desc_byte = cfg.board_type | {5'd0, size_code};
            4'd1:    desc_byte = cfg.product_id;
            4'd2:    desc_byte = cfg.board_flags;
            4'd4:    desc_byte = cfg.maker_id[15:8];
            4'd5:    desc_byte = cfg.maker_id[7:0];
            4'd6:    desc_byte = cfg.serial_number[31:24];
            4'd7:    desc_byte = cfg.serial_number[23:16];
            4'd8:    desc_byte = cfg.serial_number[15:8];
            4'd9:    desc_byte = cfg.serial_number[7:0];
            4'd10:   desc_byte = cfg.diag_vector[15:8];
            4'd11:   desc_byte = cfg.diag_vector[7:0];
            default: desc_byte = 8'h00;
        endcase
    end

    assign nib = offset[1] ? desc_byte[3:0] : desc_byte[7:4];

    always_comb
    begin
        if (!offset[0] && offset[7:6] == 2'b00)
        begin
            // first descriptor byte plain, the rest inverted
            if (offset[5:2] == 4'd0)
                rdata = {nib, 4'h0};
            else
                rdata = {~nib, 4'hF};
        end
        else if (offset == 8'h40 || offset == 8'h42)
        begin
            rdata = 8'h00;
        end
        else
        begin
            rdata = 8'hFF;
        end
    end

endmodule
